// ===== hdl/whdr_pkg.sv =====
// whdr_pkg: types, codes and constants shared by the window stacking table
// used by whdr_cell and window_hit_drag_raise, no dependencies
package whdr_pkg;

    localparam int MAX_WIN_DEF = 16;
    localparam logic [7:0] TBH_RESET = 8'd20;

    localparam logic CMD_ADD   = 1'b0;
    localparam logic CMD_MOUSE = 1'b1;

    localparam logic [2:0] ST_ADDED  = 3'd0;
    localparam logic [2:0] ST_FULL   = 3'd1;
    localparam logic [2:0] ST_IDLE   = 3'd2;
    localparam logic [2:0] ST_PICKED = 3'd3;
    localparam logic [2:0] ST_MOVED  = 3'd4;

    typedef struct packed {
        logic signed [15:0] left;
        logic signed [15:0] top;
        logic [11:0]        wide;
        logic [11:0]        tall;
        logic [3:0]         ident;
        logic signed [16:0] dx;
        logic signed [16:0] dy;
    } t_entry;

    localparam int ENT_W = $bits(t_entry);

    typedef struct packed {
        logic load_new;
        logic load_hit;
        logic load_swap;
        logic tok_load;
        logic shift;
        logic clear;
    } t_cell_cmd;

endpackage

// ===== hdl/whdr_cell.sv =====
// whdr_cell: one stacking slot, holds a window entry and the scan token
// and tests the pointer against its title bar; depends on whdr_pkg
module whdr_cell (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  whdr_pkg::t_cell_cmd i_cmd,
    input  logic               i_tok_in,
    input  whdr_pkg::t_entry   i_new_ent,
    input  whdr_pkg::t_entry   i_top_ent,
    input  whdr_pkg::t_entry   i_hit_ent,
    input  logic signed [15:0] i_px,
    input  logic signed [15:0] i_py,
    input  logic [7:0]         i_tbh,
    output whdr_pkg::t_entry   o_ent,
    output logic               o_tok,
    output logic               o_hit
);
    import whdr_pkg::*;

    t_entry r_ent;
    t_entry n_ent;
    logic   r_tok;
    logic   n_tok;

    logic signed [16:0] px17;
    logic signed [16:0] py17;
    logic signed [16:0] left17;
    logic signed [16:0] top17;
    logic signed [16:0] right17;
    logic signed [16:0] bar17;
    logic               in_bar;

    always_comb begin
        px17    = $signed({i_px[15], i_px});
        py17    = $signed({i_py[15], i_py});
        left17  = $signed({r_ent.left[15], r_ent.left});
        top17   = $signed({r_ent.top[15], r_ent.top});
        right17 = left17 + $signed({5'd0, r_ent.wide});
        bar17   = top17 - $signed({9'd0, i_tbh});
        in_bar  = (px17 >= left17) && (px17 < right17) && (py17 >= bar17) && (py17 < top17);
    end

    always_comb begin
        n_ent = r_ent;
        if (i_cmd.load_new) begin
            n_ent = i_new_ent;
        end else if (i_cmd.load_hit) begin
            n_ent = i_hit_ent;
        end else if (i_cmd.load_swap) begin
            n_ent = i_top_ent;
        end
    end

    always_comb begin
        n_tok = r_tok;
        if (i_cmd.clear) begin
            n_tok = 1'b0;
        end else if (i_cmd.tok_load) begin
            n_tok = 1'b1;
        end else if (i_cmd.shift) begin
            n_tok = i_tok_in;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ent <= n_ent;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok <= 1'b0;
        end else begin
            r_tok <= n_tok;
        end
    end

    assign o_ent = r_ent;
    assign o_tok = r_tok;
    assign o_hit = r_tok & in_bar;

endmodule

// ===== hdl/window_hit_drag_raise.sv =====
// window_hit_drag_raise: stacking table of windows with title bar hit scan,
// drag and raise to top; depends on whdr_pkg and whdr_cell
//
// channel   ports                                              handshake
// command   i_cmd i_pos_x i_pos_y i_width i_height i_button    start, busy
// result    o_status o_window_id o_slot o_win_x o_win_y        o_valid
// config    i_cfg_wdata (title bar height)                     i_cfg_we
//
// add, release and drag-move items strobe the result on the cycle after
// start. a press with no drag runs a token down the cell chain from the top
// slot, one cell per cycle, and busy is high meanwhile. synchronous reset
// empties the table and sets the title bar height to 20; the receiver
// cannot stall.
module window_hit_drag_raise #(
    parameter int MAX_WIN = whdr_pkg::MAX_WIN_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic               i_cmd,
    input  logic signed [15:0] i_pos_x,
    input  logic signed [15:0] i_pos_y,
    input  logic [11:0]        i_width,
    input  logic [11:0]        i_height,
    input  logic               i_button,
    input  logic               i_cfg_we,
    input  logic [7:0]         i_cfg_wdata,
    output logic               o_valid,
    output logic [2:0]         o_status,
    output logic [3:0]         o_window_id,
    output logic [3:0]         o_slot,
    output logic signed [15:0] o_win_x,
    output logic signed [15:0] o_win_y
);
    import whdr_pkg::*;

    localparam int CW = $clog2(MAX_WIN + 1);
    localparam int IW = $clog2(MAX_WIN);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_SCAN = 1'b1;

    logic               r_state, n_state;
    logic [CW-1:0]      r_count, n_count;
    logic               r_drag, n_drag;
    logic [7:0]         r_tbh;
    logic signed [15:0] r_px, r_py;
    logic               r_valid, n_valid;
    logic [2:0]         r_status, n_status;
    logic [3:0]         r_id, n_id;
    logic [3:0]         r_slot, n_slot;
    logic signed [15:0] r_x, r_y;
    logic signed [15:0] n_x, n_y;

    t_cell_cmd          c_cmd [MAX_WIN];
    t_entry             c_ent [MAX_WIN];
    logic [MAX_WIN-1:0] c_tok;
    logic [MAX_WIN-1:0] c_hit;
    logic [MAX_WIN-1:0] c_tok_in;

    logic [ENT_W-1:0]   top_bus;
    logic [ENT_W-1:0]   hit_bus;
    t_entry             top_ent;
    t_entry             hit_ent;
    t_entry             grab_ent;
    t_entry             new_ent;
    t_entry             move_ent;

    logic [IW-1:0]      top_idx;
    logic               accept;
    logic               is_add;
    logic               full;
    logic               do_add;
    logic               released;
    logic               do_move;
    logic               do_scan;
    logic               found;
    logic               miss;
    logic signed [17:0] mx, my;

    function automatic logic signed [15:0] sat16(input logic signed [17:0] v);
        logic signed [15:0] r;
        if (v > 18'sd32767) begin
            r = 16'sh7FFF;
        end else if (v < -18'sd32768) begin
            r = 16'sh8000;
        end else begin
            r = v[15:0];
        end
        return r;
    endfunction

    genvar g;
    generate
        for (g = 0; g < MAX_WIN; g++) begin : g_cell
            if (g == MAX_WIN - 1) begin : g_last
                assign c_tok_in[g] = 1'b0;
            end else begin : g_mid
                assign c_tok_in[g] = c_tok[g+1];
            end
            whdr_cell u_cell (
                .i_clk     (i_clk),
                .i_rst_n   (i_rst_n),
                .i_cmd     (c_cmd[g]),
                .i_tok_in  (c_tok_in[g]),
                .i_new_ent (new_ent),
                .i_top_ent (top_ent),
                .i_hit_ent (grab_ent),
                .i_px      (r_px),
                .i_py      (r_py),
                .i_tbh     (r_tbh),
                .o_ent     (c_ent[g]),
                .o_tok     (c_tok[g]),
                .o_hit     (c_hit[g])
            );
        end
    endgenerate

    assign top_idx = IW'(r_count - CW'(1));

    always_comb begin
        top_bus = '0;
        hit_bus = '0;
        for (int k = 0; k < MAX_WIN; k++) begin
            if (IW'(k) == top_idx) begin
                top_bus = top_bus | c_ent[k];
            end
            if (c_hit[k]) begin
                hit_bus = hit_bus | c_ent[k];
            end
        end
        top_ent = t_entry'(top_bus);
        hit_ent = t_entry'(hit_bus);
    end

    always_comb begin
        busy     = (r_state == S_SCAN);
        accept   = start & ~busy;
        is_add   = (i_cmd == CMD_ADD);
        full     = (r_count >= CW'(MAX_WIN));
        do_add   = accept & is_add & ~full;
        released = ~i_button | (r_count == '0);
        do_move  = accept & ~is_add & ~released & r_drag;
        do_scan  = accept & ~is_add & ~released & ~r_drag;
        found    = busy & (|c_hit);
        miss     = busy & ~found & c_tok[0];

        mx = $signed({{2{i_pos_x[15]}}, i_pos_x}) - $signed({top_ent.dx[16], top_ent.dx});
        my = $signed({{2{i_pos_y[15]}}, i_pos_y}) - $signed({top_ent.dy[16], top_ent.dy});
        move_ent      = top_ent;
        move_ent.left = sat16(mx);
        move_ent.top  = sat16(my);

        new_ent = move_ent;
        if (is_add) begin
            new_ent.left  = i_pos_x;
            new_ent.top   = i_pos_y;
            new_ent.wide  = i_width;
            new_ent.tall  = i_height;
            new_ent.ident = 4'(r_count);
            new_ent.dx    = '0;
            new_ent.dy    = '0;
        end

        grab_ent    = hit_ent;
        grab_ent.dx = $signed({r_px[15], r_px}) - $signed({hit_ent.left[15], hit_ent.left});
        grab_ent.dy = $signed({r_py[15], r_py}) - $signed({hit_ent.top[15], hit_ent.top});
    end

    always_comb begin
        for (int k = 0; k < MAX_WIN; k++) begin
            c_cmd[k].load_new  = (do_add & (CW'(k) == r_count))
                               | (do_move & (IW'(k) == top_idx));
            c_cmd[k].load_hit  = found & (IW'(k) == top_idx);
            c_cmd[k].load_swap = found & c_hit[k];
            c_cmd[k].tok_load  = do_scan & (IW'(k) == top_idx);
            c_cmd[k].shift     = busy;
            c_cmd[k].clear     = found | miss;
        end
    end

    always_comb begin
        n_state  = r_state;
        n_count  = r_count;
        n_drag   = r_drag;
        n_valid  = 1'b0;
        n_status = ST_IDLE;
        n_id     = '0;
        n_slot   = '0;
        n_x      = '0;
        n_y      = '0;
        if (accept) begin
            n_valid = 1'b1;
            if (is_add) begin
                n_drag = 1'b0;
                if (full) begin
                    n_status = ST_FULL;
                end else begin
                    n_count  = r_count + CW'(1);
                    n_status = ST_ADDED;
                    n_id     = 4'(r_count);
                    n_slot   = 4'(r_count);
                    n_x      = i_pos_x;
                    n_y      = i_pos_y;
                end
            end else if (released) begin
                n_drag = 1'b0;
            end else if (r_drag) begin
                n_status = ST_MOVED;
                n_id     = top_ent.ident;
                n_slot   = 4'(top_idx);
                n_x      = move_ent.left;
                n_y      = move_ent.top;
            end else begin
                n_valid = 1'b0;
                n_state = S_SCAN;
            end
        end else if (found) begin
            n_valid  = 1'b1;
            n_state  = S_IDLE;
            n_drag   = 1'b1;
            n_status = ST_PICKED;
            n_id     = hit_ent.ident;
            n_slot   = 4'(top_idx);
            n_x      = hit_ent.left;
            n_y      = hit_ent.top;
        end else if (miss) begin
            n_valid = 1'b1;
            n_state = S_IDLE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_drag  <= 1'b0;
            r_tbh   <= TBH_RESET;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_drag  <= n_drag;
            r_valid <= n_valid;
            if (i_cfg_we) begin
                r_tbh <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_scan) begin
            r_px <= i_pos_x;
            r_py <= i_pos_y;
        end
        r_status <= n_status;
        r_id     <= n_id;
        r_slot   <= n_slot;
        r_x      <= n_x;
        r_y      <= n_y;
    end

    assign o_valid     = r_valid;
    assign o_status    = r_status;
    assign o_window_id = r_id;
    assign o_slot      = r_slot;
    assign o_win_x     = r_x;
    assign o_win_y     = r_y;

    a_scan_no_drag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> !r_drag)
        else $error("scan running while a drag is active");

    a_one_token: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(c_tok))
        else $error("more than one scan token in the chain");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(MAX_WIN))
        else $error("window count beyond table size");

    a_pick_drags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && (r_status == ST_PICKED)) |-> (r_drag && (r_count != '0)))
        else $error("pick-up reported without a drag in progress");

endmodule

// ===== bench/tb_window_hit_drag_raise.sv =====
// tb_window_hit_drag_raise: self-checking bench for the window stacking table with
// title bar hit scan, drag and raise; a queue-fed driver, a result monitor and an
// in-bench copy of the table state. depends on whdr_pkg and window_hit_drag_raise
module tb_window_hit_drag_raise;
    timeunit 1ns;
    timeprecision 1ps;

    import whdr_pkg::*;

    localparam int MAX_WIN = MAX_WIN_DEF;
    localparam int CYCLE_LIMIT = 600000;

    typedef struct {
        logic               op;
        logic signed [15:0] px;
        logic signed [15:0] py;
        logic [11:0]        w;
        logic [11:0]        h;
        logic               btn;
        int                 gap;
    } t_cmd;

    typedef struct {
        logic [2:0]         status;
        logic [3:0]         ident;
        logic [3:0]         slot;
        logic signed [15:0] x;
        logic signed [15:0] y;
    } t_report;

    logic               i_clk;
    logic               i_rst_n = 1'b0;
    logic               start = 1'b0;
    logic               busy;
    logic               i_cmd = CMD_ADD;
    logic signed [15:0] i_pos_x = '0;
    logic signed [15:0] i_pos_y = '0;
    logic [11:0]        i_width = '0;
    logic [11:0]        i_height = '0;
    logic               i_button = 1'b0;
    logic               i_cfg_we = 1'b0;
    logic [7:0]         i_cfg_wdata = '0;
    logic               o_valid;
    logic [2:0]         o_status;
    logic [3:0]         o_window_id;
    logic [3:0]         o_slot;
    logic signed [15:0] o_win_x;
    logic signed [15:0] o_win_y;

    t_cmd    cmd_q[$];
    t_report report_q[$];
    t_cmd    cur;
    int      gap_left;
    bit      gap_armed;
    bit      calm;
    int      issued;
    int      err_cnt;
    int      rpt_cnt;
    int      cycles;

    t_entry  wins [MAX_WIN];
    int      win_total = 0;
    bit      dragging = 1'b0;
    int      bar_h = int'(TBH_RESET);

    window_hit_drag_raise #(
        .MAX_WIN(MAX_WIN)
    ) u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_cmd      (i_cmd),
        .i_pos_x    (i_pos_x),
        .i_pos_y    (i_pos_y),
        .i_width    (i_width),
        .i_height   (i_height),
        .i_button   (i_button),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_wdata(i_cfg_wdata),
        .o_valid    (o_valid),
        .o_status   (o_status),
        .o_window_id(o_window_id),
        .o_slot     (o_slot),
        .o_win_x    (o_win_x),
        .o_win_y    (o_win_y)
    );

    function automatic logic signed [15:0] clamp16(int v);
        if (v > 32767) return 16'h7fff;
        if (v < -32768) return 16'h8000;
        return 16'(v);
    endfunction

    function automatic int rand_pos();
        return int'($urandom_range(0, 65535)) - 32768;
    endfunction

    function automatic t_report table_step(t_cmd c);
        t_report r;
        t_entry  e;
        int      top_i, k, l, t, px, py;
        r = '{status: ST_IDLE, ident: '0, slot: '0, x: '0, y: '0};
        px = $signed(c.px);
        py = $signed(c.py);
        if (c.op == CMD_ADD) begin
            dragging = 1'b0;
            if (win_total >= MAX_WIN) begin
                r.status = ST_FULL;
                return r;
            end
            wins[win_total] = '{left: c.px, top: c.py, wide: c.w, tall: c.h,
                                ident: 4'(win_total), dx: '0, dy: '0};
            r = '{status: ST_ADDED, ident: 4'(win_total), slot: 4'(win_total),
                  x: c.px, y: c.py};
            win_total++;
            return r;
        end
        if (!c.btn || win_total == 0) begin
            dragging = 1'b0;
            return r;
        end
        top_i = win_total - 1;
        if (dragging) begin
            wins[top_i].left = clamp16(px - $signed(wins[top_i].dx));
            wins[top_i].top = clamp16(py - $signed(wins[top_i].dy));
            r = '{status: ST_MOVED, ident: wins[top_i].ident, slot: 4'(top_i),
                  x: wins[top_i].left, y: wins[top_i].top};
            return r;
        end
        for (k = top_i; k >= 0; k--) begin
            l = $signed(wins[k].left);
            t = $signed(wins[k].top);
            if (px >= l && px < l + int'(wins[k].wide) && py >= t - bar_h && py < t) begin
                wins[k].dx = 17'(px - l);
                wins[k].dy = 17'(py - t);
                e = wins[k];
                wins[k] = wins[top_i];
                wins[top_i] = e;
                dragging = 1'b1;
                r = '{status: ST_PICKED, ident: e.ident, slot: 4'(top_i),
                      x: e.left, y: e.top};
                return r;
            end
        end
        return r;
    endfunction

    task automatic queue_cmd(logic op, int px, int py, int w, int h, logic btn);
        t_cmd c;
        c = '{op: op, px: clamp16(px), py: clamp16(py), w: 12'(w), h: 12'(h),
              btn: btn, gap: calm ? 0 : int'($urandom_range(0, 10))};
        cmd_q.push_back(c);
        issued++;
    endtask

    task automatic queue_add();
        if ($urandom_range(0, 3) == 0)
            queue_cmd(CMD_ADD, rand_pos(), rand_pos(), $urandom_range(0, 4095),
                      $urandom_range(0, 4095), 1'($urandom_range(0, 1)));
        else
            queue_cmd(CMD_ADD, int'($urandom_range(0, 1200)) - 600,
                      int'($urandom_range(0, 1200)) - 600, $urandom_range(0, 700),
                      $urandom_range(0, 700), 1'($urandom_range(0, 1)));
    endtask

    task automatic wait_idle();
        do @(negedge i_clk);
        while (cmd_q.size() != 0 || start || report_q.size() != 0);
    endtask

    task automatic set_bar(int v);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= 8'(v);
        bar_h = v;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic log_fault(string msg);
        err_cnt++;
        if (err_cnt <= 10) $display("%s", msg);
    endtask

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("window_hit_drag_raise: mismatch");
            $finish;
        end
    end

    always @(posedge i_clk) begin : drive
        logic go;
        go = start;
        if (!i_rst_n) begin
            go = 1'b0;
            gap_armed = 1'b0;
        end else begin
            if (start && !busy) begin
                report_q.push_back(table_step(cur));
                go = 1'b0;
            end
            if (!go && cmd_q.size() != 0) begin
                if (!gap_armed) begin
                    gap_left = cmd_q[0].gap;
                    gap_armed = 1'b1;
                end
                if (gap_left != 0) begin
                    gap_left--;
                end else begin
                    cur = cmd_q.pop_front();
                    gap_armed = 1'b0;
                    i_cmd <= cur.op;
                    i_pos_x <= cur.px;
                    i_pos_y <= cur.py;
                    i_width <= cur.w;
                    i_height <= cur.h;
                    i_button <= cur.btn;
                    go = 1'b1;
                end
            end
        end
        start <= go;
    end

    always @(posedge i_clk) begin : watch
        t_report want;
        if (i_rst_n && o_valid) begin
            rpt_cnt++;
            if (report_q.size() == 0) begin
                log_fault($sformatf("report %0d: none expected, got st=%0d id=%0d",
                                    rpt_cnt, o_status, o_window_id));
            end else begin
                want = report_q.pop_front();
                if (o_status !== want.status || o_window_id !== want.ident ||
                    o_slot !== want.slot || o_win_x !== want.x || o_win_y !== want.y)
                    log_fault($sformatf({"report %0d: exp st=%0d id=%0d slot=%0d",
                                         " x=%0d y=%0d, got st=%0d id=%0d slot=%0d",
                                         " x=%0d y=%0d"},
                        rpt_cnt, want.status, want.ident, want.slot, want.x, want.y,
                        o_status, o_window_id, o_slot, o_win_x, o_win_y));
            end
        end
    end

    initial begin
        int heights [5];
        int lens [5];
        int ph, k, l, t, wd, ax, ay, n, phase_end, kind;
        heights = '{1, 0, 255, 0, 20};
        lens = '{400, 150, 450, 450, 450};
        heights[3] = $urandom_range(2, 254);
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        calm = 1'b0;
        queue_cmd(CMD_MOUSE, 0, 0, 4095, 0, 1'b1);
        queue_cmd(CMD_MOUSE, 0, 0, 0, 4095, 1'b0);
        queue_cmd(CMD_ADD, -32768, -32768, 4095, 4095, 1'b0);
        queue_cmd(CMD_ADD, 100, 200, 300, 50, 1'b1);
        queue_cmd(CMD_ADD, 32767, 32767, 0, 0, 1'b0);
        queue_cmd(CMD_ADD, 150, 210, 100, 40, 1'b1);
        // two bars overlap here, the upper one wins
        queue_cmd(CMD_MOUSE, 160, 195, 0, 0, 1'b1);
        queue_cmd(CMD_MOUSE, -32768, 32767, 4095, 4095, 1'b1);
        queue_cmd(CMD_MOUSE, 500, 600, 0, 0, 1'b1);
        queue_cmd(CMD_MOUSE, 500, 600, 0, 0, 1'b0);
        // lower window gets raised
        queue_cmd(CMD_MOUSE, 120, 185, 0, 0, 1'b1);
        queue_cmd(CMD_MOUSE, 399, 180, 0, 0, 1'b1);
        // add in the middle of a drag
        queue_cmd(CMD_ADD, -5, -5, 1, 1, 1'b0);
        queue_cmd(CMD_MOUSE, -5, -25, 0, 0, 1'b1);
        queue_cmd(CMD_MOUSE, 0, 0, 0, 0, 1'b0);
        queue_cmd(CMD_MOUSE, -4, -6, 0, 0, 1'b1);
        queue_cmd(CMD_MOUSE, 32767, 32757, 0, 0, 1'b1);
        queue_cmd(CMD_MOUSE, 32767, -32768, 4095, 4095, 1'b0);
        wait_idle();
        set_bar(0);
        queue_cmd(CMD_MOUSE, -5, -6, 0, 0, 1'b1);
        queue_cmd(CMD_MOUSE, -5, -6, 0, 0, 1'b0);
        wait_idle();
        set_bar(255);
        queue_cmd(CMD_MOUSE, -5, -260, 0, 0, 1'b1);
        queue_cmd(CMD_MOUSE, 32767, 32767, 0, 0, 1'b1);
        queue_cmd(CMD_MOUSE, 0, 0, 0, 0, 1'b0);

        for (ph = 0; ph < 5; ph++) begin
            wait_idle();
            repeat (2) @(posedge i_clk);
            set_bar(heights[ph]);
            phase_end = issued + lens[ph];
            while (issued < phase_end) begin
                calm = ($urandom_range(0, 3) == 0);
                kind = $urandom_range(0, 9);
                if (kind < 5 && win_total != 0) begin
                    // aimed press, a few moves, then mostly a release
                    wait_idle();
                    k = $urandom_range(0, win_total - 1);
                    l = $signed(wins[k].left);
                    t = $signed(wins[k].top);
                    wd = int'(wins[k].wide);
                    case ($urandom_range(0, 5))
                        0: begin
                            ax = l;
                            ay = t - bar_h;
                        end
                        1: begin
                            ax = l + wd - 1;
                            ay = t - 1;
                        end
                        default: begin
                            ax = l + ((wd > 0) ? int'($urandom_range(0, wd - 1)) : 0);
                            ay = t - ((bar_h > 0) ? int'($urandom_range(1, bar_h)) : 0);
                        end
                    endcase
                    queue_cmd(CMD_MOUSE, ax, ay, $urandom_range(0, 4095),
                              $urandom_range(0, 4095), 1'b1);
                    n = $urandom_range(0, 6);
                    repeat (n) begin
                        if ($urandom_range(0, 7) == 0) begin
                            ax = $urandom_range(0, 1) ? 32767 : -32768;
                            ay = $urandom_range(0, 1) ? 32767 : -32768;
                        end else begin
                            ax = int'(clamp16(ax + int'($urandom_range(0, 400)) - 200));
                            ay = int'(clamp16(ay + int'($urandom_range(0, 400)) - 200));
                        end
                        queue_cmd(CMD_MOUSE, ax, ay, $urandom_range(0, 4095),
                                  $urandom_range(0, 4095), 1'b1);
                    end
                    case ($urandom_range(0, 5))
                        0: queue_add();
                        1: ;
                        default: queue_cmd(CMD_MOUSE, rand_pos(), rand_pos(),
                                           $urandom_range(0, 4095),
                                           $urandom_range(0, 4095), 1'b0);
                    endcase
                end else if (kind >= 5 && kind < 7) begin
                    queue_add();
                end else begin
                    queue_cmd(CMD_MOUSE, rand_pos(), rand_pos(), $urandom_range(0, 4095),
                              $urandom_range(0, 4095), 1'($urandom_range(0, 1)));
                end
            end
        end

        wait_idle();
        repeat (MAX_WIN + 4) @(posedge i_clk);
        err_cnt += report_q.size();
        if (err_cnt == 0)
            $display("window_hit_drag_raise: match");
        else
            $display("window_hit_drag_raise: mismatch");
        $finish;
    end

endmodule
